// ===== rtl/tfsi_pkg.sv =====
// shared constants for the tensor flip source index generator
`timescale 1ns / 1ps
package tfsi_pkg;

  // field widths
  localparam int IDX_W  = 32;
  localparam int SIZE_W = 16;
  localparam int DIMS_W = 3;
  localparam int MASK_W = 4;
  localparam int CFG_W  = 16;
  localparam int REG_W  = 3;

  // dimension count limit and divider slicing
  localparam int MAX_DIMS_DEF   = 4;
  localparam int CFG_DIMS       = 4;
  localparam int BITS_PER_STEP  = 4;
  localparam int STEPS_PER_DIM  = IDX_W / BITS_PER_STEP;

  // register indexes
  localparam logic [REG_W-1:0] REG_DIMS  = 3'd0;
  localparam logic [REG_W-1:0] REG_SIZE0 = 3'd1;
  localparam logic [REG_W-1:0] REG_SIZE1 = 3'd2;
  localparam logic [REG_W-1:0] REG_SIZE2 = 3'd3;
  localparam logic [REG_W-1:0] REG_SIZE3 = 3'd4;
  localparam logic [REG_W-1:0] REG_FLIP  = 3'd5;

endpackage

// ===== rtl/tfsi_if.sv =====
// channel interfaces for index, result and register write transfers
`timescale 1ns / 1ps
interface tfsi_idx_if;
  logic                       valid;
  logic                       ready;
  logic [tfsi_pkg::IDX_W-1:0] out_index;
  modport source (output valid, output out_index, input ready);
  modport sink (input valid, input out_index, output ready);
endinterface

interface tfsi_res_if;
  logic                       valid;
  logic                       ready;
  logic [tfsi_pkg::IDX_W-1:0] src_offset;
  logic                       out_of_range;
  modport source (output valid, output src_offset, output out_of_range, input ready);
  modport sink (input valid, input src_offset, input out_of_range, output ready);
endinterface

interface tfsi_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tfsi_pkg::REG_W-1:0] index;
  logic [tfsi_pkg::CFG_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tensor_flip_source_index.sv =====
// Path: an index passes the divider stages, then the mirror and scale stage, then the sum stage.
// Throughput: one index per cycle while the output is not stalled; the 4-bit-per-stage divider
//   pipeline, 8 stages for each dimension, sets the depth, and every stage holds one item.
// Stalls back up stage by stage, so bubbles fill while the result waits.
// Reset clears all stage valid bits and loads the registers with their reset values.
// top level: pipelined split, mirror and recombine of a row-major tensor index
`timescale 1ns / 1ps
module tensor_flip_source_index #(
  parameter int MAX_DIMS = tfsi_pkg::MAX_DIMS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tfsi_cfg_if.sink   cfg_i,
  tfsi_idx_if.sink   in_i,
  tfsi_res_if.source out_o
);

  localparam int IW    = tfsi_pkg::IDX_W;
  localparam int SW    = tfsi_pkg::SIZE_W;
  localparam int STEPS = tfsi_pkg::STEPS_PER_DIM;
  localparam int BPS   = tfsi_pkg::BITS_PER_STEP;
  localparam int NDIV  = MAX_DIMS * STEPS;
  localparam int NSTG  = NDIV + 2;

  // configuration registers
  logic [tfsi_pkg::DIMS_W-1:0] dims_q;
  logic [SW-1:0]               size_q [tfsi_pkg::CFG_DIMS];
  logic [tfsi_pkg::MASK_W-1:0] flip_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= tfsi_pkg::DIMS_W'(1);
      for (int i = 0; i < tfsi_pkg::CFG_DIMS; i++) size_q[i] <= SW'(1);
      flip_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        tfsi_pkg::REG_DIMS:  dims_q    <= cfg_i.data[tfsi_pkg::DIMS_W-1:0];
        tfsi_pkg::REG_SIZE0: size_q[0] <= cfg_i.data[SW-1:0];
        tfsi_pkg::REG_SIZE1: size_q[1] <= cfg_i.data[SW-1:0];
        tfsi_pkg::REG_SIZE2: size_q[2] <= cfg_i.data[SW-1:0];
        tfsi_pkg::REG_SIZE3: size_q[3] <= cfg_i.data[SW-1:0];
        tfsi_pkg::REG_FLIP:  flip_q    <= cfg_i.data[tfsi_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes: unused dimensions count as extent one
  logic [tfsi_pkg::DIMS_W-1:0] dims_eff;
  logic [SW-1:0]               eff    [MAX_DIMS];
  logic [SW-1:0]               effm1  [MAX_DIMS];
  logic                        zero_any;

  always_comb begin
    dims_eff = dims_q;
    if (dims_q == '0) dims_eff = tfsi_pkg::DIMS_W'(1);
    if (32'(dims_q) > MAX_DIMS) dims_eff = tfsi_pkg::DIMS_W'(MAX_DIMS);
    zero_any = 1'b0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      eff[d]   = (32'(d) < 32'(dims_eff)) ? size_q[d] : SW'(1);
      effm1[d] = eff[d] - SW'(1);
      if (eff[d] == '0) zero_any = 1'b1;
    end
  end

  // row-major strides, each registered from the stride and extent of the next dimension
  logic [IW-1:0] stride_q [MAX_DIMS];

  always_ff @(posedge clk_i) begin
    stride_q[MAX_DIMS-1] <= IW'(1);
    for (int d = 0; d < MAX_DIMS - 1; d++) begin
      stride_q[d] <= IW'(stride_q[d+1] * eff[d+1]);
    end
  end

  // stage handshake: a stage loads when empty or when the next one moves
  logic [NSTG-1:0] valid_q;
  logic [NSTG-1:0] rdy;

  assign rdy[NSTG-1] = !valid_q[NSTG-1] || out_o.ready;
  for (genvar s = 0; s < NSTG - 1; s++) begin : g_rdy
    assign rdy[s] = !valid_q[s] || rdy[s+1];
  end
  assign in_i.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) valid_q[0] <= in_i.valid;
      for (int s = 1; s < NSTG; s++) begin
        if (rdy[s]) valid_q[s] <= valid_q[s-1];
      end
    end
  end

  // divider stages: dividend shifts out, quotient shifts in, four bits a stage
  logic [IW-1:0] work_q  [NDIV];
  logic [SW-1:0] rem_q   [NDIV];
  logic [SW-1:0] coord_q [NDIV][MAX_DIMS];

  for (genvar p = 0; p < NDIV; p++) begin : g_div
    localparam int D = MAX_DIMS - 1 - p / STEPS;
    localparam int J = p % STEPS;

    logic [IW-1:0] w_in;
    logic [SW-1:0] r_in;
    logic [SW-1:0] c_in [MAX_DIMS];
    logic [IW-1:0] w;
    logic [SW:0]   r;

    if (p == 0) begin : g_first
      assign w_in = in_i.out_index;
      assign r_in = '0;
      for (genvar d = 0; d < MAX_DIMS; d++) begin : g_c
        assign c_in[d] = '0;
      end
    end else begin : g_next
      assign w_in = work_q[p-1];
      assign r_in = rem_q[p-1];
      for (genvar d = 0; d < MAX_DIMS; d++) begin : g_c
        assign c_in[d] = coord_q[p-1][d];
      end
    end

    always_comb begin
      r = {1'b0, r_in};
      w = w_in;
      for (int b = 0; b < BPS; b++) begin
        r = {r[SW-1:0], w[IW-1]};
        w = {w[IW-2:0], 1'b0};
        if (r >= {1'b0, eff[D]}) begin
          r    = r - {1'b0, eff[D]};
          w[0] = 1'b1;
        end
      end
    end

    // last step of a dimension drops the remainder in as its coordinate
    always_ff @(posedge clk_i) begin
      if (rdy[p]) begin
        work_q[p] <= w;
        rem_q[p]  <= (J == STEPS - 1) ? '0 : r[SW-1:0];
        for (int d = 0; d < MAX_DIMS; d++) begin
          coord_q[p][d] <= (J == STEPS - 1 && d == D) ? r[SW-1:0] : c_in[d];
        end
      end
    end
  end

  // mirror flipped coordinates and scale by stride
  logic [IW-1:0] prod_q [MAX_DIMS];
  logic          oor_p_q;
  logic [SW-1:0] cflip  [MAX_DIMS];

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      cflip[d] = flip_q[d] ? (effm1[d] - coord_q[NDIV-1][d]) : coord_q[NDIV-1][d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NDIV]) begin
      oor_p_q <= (work_q[NDIV-1] != '0) || zero_any;
      for (int d = 0; d < MAX_DIMS; d++) begin
        prod_q[d] <= IW'(cflip[d] * stride_q[d]);
      end
    end
  end

  // sum of terms into the output register
  logic [IW-1:0] sum;
  logic [IW-1:0] off_q;
  logic          oor_q;

  always_comb begin
    sum = '0;
    for (int d = 0; d < MAX_DIMS; d++) sum = sum + prod_q[d];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NSTG-1]) begin
      off_q <= oor_p_q ? '0 : sum;
      oor_q <= oor_p_q;
    end
  end

  assign out_o.valid        = valid_q[NSTG-1];
  assign out_o.src_offset   = off_q;
  assign out_o.out_of_range = oor_q;

`ifndef NO_ASSERTIONS
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.out_of_range |-> out_o.src_offset == '0)
    else $error("out of range result with nonzero offset");

  a_in_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> valid_q[0])
    else $error("transfer did not enter first stage");

  a_zero_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[NDIV-1] && rdy[NDIV] && zero_any |=> oor_p_q)
    else $error("zero extent not flagged");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[NDIV] && !rdy[NDIV] |=> valid_q[NDIV] && $stable(oor_p_q))
    else $error("stalled stage lost its item");
`endif

endmodule
